// ===== hdl/sensor_packet_framer_assert.svh =====
// Assertion macros used by the top level of the packet framer.
`ifndef SENSOR_PACKET_FRAMER_ASSERT_SVH
`define SENSOR_PACKET_FRAMER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SPF_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SPF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/spf_pkg.sv =====
// Shared types, constants and register indexes of the sensor packet framer.
`default_nettype none

package spf_pkg;

	// Packet geometry defaults.
	localparam int PACKET_BYTES_DEF = 38;
	localparam int SYNC_BYTES_DEF = 4;

	// Width of a packet position; packets hold at most 64 bytes.
	localparam int POS_W = 6;
	localparam int BYTE_W = 8;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_SYNC_VALUE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_ID = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MESSAGE_ID = 2'd2;

	// Register reset values.
	localparam logic [BYTE_W-1:0] SYNC_VALUE_RST = 8'hFF;
	localparam logic [BYTE_W-1:0] DEVICE_ID_RST = 8'hFF;
	localparam logic [BYTE_W-1:0] MESSAGE_ID_RST = 8'h14;

	// Parse phase codes.
	typedef logic [1:0] spf_phase_t;
	localparam spf_phase_t PH_SYNC = 2'd0;
	localparam spf_phase_t PH_HEADER = 2'd1;
	localparam spf_phase_t PH_PAYLOAD = 2'd2;
	localparam spf_phase_t PH_CHECK = 2'd3;

	typedef struct packed {
		logic keep;       // store the input byte, add it to the sum, count it
		logic clear;      // drop the frame: count and sum back to zero
		logic load_last;  // latch the checksum byte and rewind the read pointer
		logic advance;    // the output item is taken this cycle
	} spf_cmd_t;

	typedef struct packed {
		logic byte_match;        // input byte equals the expected sync or header value
		logic sum_match;         // input byte equals the running sum
		logic ptr_last;          // the output item is the final packet byte
		spf_phase_t next_phase;  // phase after storing one more byte
	} spf_status_t;

endpackage

`default_nettype wire

// ===== hdl/spf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module spf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 38
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ===== hdl/spf_ctrl.sv =====
// Controller state machine of the sensor packet framer.
`default_nettype none

module spf_ctrl
	import spf_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire logic        out_stall,
	input  wire spf_status_t status,
	output logic             in_stall,
	output logic             out_valid,
	output spf_cmd_t         cmd
);

	// The four parse states share their codes with the parse phases.
	localparam logic [2:0] ST_SYNC = {1'b0, PH_SYNC};
	localparam logic [2:0] ST_HEADER = {1'b0, PH_HEADER};
	localparam logic [2:0] ST_PAYLOAD = {1'b0, PH_PAYLOAD};
	localparam logic [2:0] ST_CHECK = {1'b0, PH_CHECK};
	localparam logic [2:0] ST_EMIT = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       in_take;

	assign in_stall = (state_q == ST_EMIT);
	assign out_valid = (state_q == ST_EMIT);
	assign in_take = in_valid && !in_stall;

	always_comb begin
		cmd = '0;
		state_d = state_q;
		case (state_q)
			ST_SYNC, ST_HEADER: begin
				if (in_take) begin
					if (status.byte_match) begin
						cmd.keep = 1'b1;
						state_d = {1'b0, status.next_phase};
					end else begin
						cmd.clear = 1'b1;
						state_d = ST_SYNC;
					end
				end
			end
			ST_PAYLOAD: begin
				if (in_take) begin
					cmd.keep = 1'b1;
					state_d = {1'b0, status.next_phase};
				end
			end
			ST_CHECK: begin
				if (in_take) begin
					cmd.clear = 1'b1;
					if (status.sum_match) begin
						cmd.load_last = 1'b1;
						state_d = ST_EMIT;
					end else begin
						state_d = ST_SYNC;
					end
				end
			end
			ST_EMIT: begin
				cmd.advance = !out_stall;
				if (!out_stall && status.ptr_last) begin
					state_d = ST_SYNC;
				end
			end
			default: begin
				state_d = ST_SYNC;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_SYNC;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/spf_dp.sv =====
// Datapath of the sensor packet framer: registers, packet memory, checks, output.
`default_nettype none

module spf_dp
	import spf_pkg::*;
#(
	parameter int PACKET_BYTES = PACKET_BYTES_DEF,
	parameter int SYNC_BYTES = SYNC_BYTES_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [BYTE_W-1:0]    cfg_data,
	input  wire logic [BYTE_W-1:0]    rx_byte,
	input  wire spf_cmd_t             cmd,
	output spf_status_t               status,
	output logic      [BYTE_W-1:0]    packet_byte,
	output logic      [POS_W-1:0]     byte_position,
	output logic                      last_byte
);

	localparam int AW = $clog2(PACKET_BYTES);
	localparam logic [POS_W-1:0] LAST_POS = POS_W'(PACKET_BYTES - 1);
	localparam logic [POS_W-1:0] SYNC_END = POS_W'(SYNC_BYTES);
	localparam logic [POS_W-1:0] HDR_END = POS_W'(SYNC_BYTES + 3);
	localparam logic [BYTE_W-1:0] LEN_BYTE = BYTE_W'(PACKET_BYTES);

	logic [BYTE_W-1:0] sync_value_q;
	logic [BYTE_W-1:0] device_id_q;
	logic [BYTE_W-1:0] message_id_q;
	logic [POS_W-1:0]  count_q;
	logic [BYTE_W-1:0] sum_q;
	logic [POS_W-1:0]  ptr_q;
	logic [POS_W-1:0]  ptr_d;
	logic [BYTE_W-1:0] last_q;
	logic [BYTE_W-1:0] rd_data;
	logic [BYTE_W-1:0] want;
	logic [POS_W-1:0]  hdr_pos;
	logic [POS_W-1:0]  count_inc;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_value_q <= SYNC_VALUE_RST;
			device_id_q <= DEVICE_ID_RST;
			message_id_q <= MESSAGE_ID_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SYNC_VALUE: sync_value_q <= cfg_data;
				CFG_DEVICE_ID:  device_id_q <= cfg_data;
				CFG_MESSAGE_ID: message_id_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Expected value of the next sync or header byte, chosen by the frame count.
	assign hdr_pos = count_q - SYNC_END;

	always_comb begin
		if (count_q < SYNC_END) begin
			want = sync_value_q;
		end else begin
			case (hdr_pos)
				POS_W'(0): want = LEN_BYTE;
				POS_W'(1): want = device_id_q;
				default:   want = message_id_q;
			endcase
		end
	end

	assign count_inc = count_q + POS_W'(1);

	always_comb begin
		if (count_inc >= LAST_POS) begin
			status.next_phase = PH_CHECK;
		end else if (count_inc < SYNC_END) begin
			status.next_phase = PH_SYNC;
		end else if (count_inc < HDR_END) begin
			status.next_phase = PH_HEADER;
		end else begin
			status.next_phase = PH_PAYLOAD;
		end
	end

	assign status.byte_match = (rx_byte == want);
	assign status.sum_match = (rx_byte == sum_q);
	assign status.ptr_last = (ptr_q == LAST_POS);

	// Frame count and running checksum.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			sum_q <= '0;
		end else if (cmd.clear) begin
			count_q <= '0;
			sum_q <= '0;
		end else if (cmd.keep) begin
			count_q <= count_inc;
			sum_q <= sum_q + rx_byte;
		end
	end

	// The read address runs one position ahead of the item on the output, so the
	// registered read data always belongs to the current output position.
	always_comb begin
		ptr_d = ptr_q;
		if (cmd.load_last) begin
			ptr_d = '0;
		end else if (cmd.advance) begin
			ptr_d = status.ptr_last ? '0 : ptr_q + POS_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q <= '0;
		end else begin
			ptr_q <= ptr_d;
		end
	end

	// The checksum byte is held here rather than in the packet memory.
	always_ff @(posedge clk) begin
		if (cmd.load_last) begin
			last_q <= rx_byte;
		end
	end

	spf_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(PACKET_BYTES)
	) u_store (
		.clk  (clk),
		.we   (cmd.keep),
		.waddr(count_q[AW-1:0]),
		.wdata(rx_byte),
		.raddr(ptr_d[AW-1:0]),
		.rdata(rd_data)
	);

	assign packet_byte = status.ptr_last ? last_q : rd_data;
	assign byte_position = ptr_q;
	assign last_byte = status.ptr_last;

endmodule

`default_nettype wire

// ===== hdl/sensor_packet_framer.sv =====
// Top level of the sensor packet framer: controller and datapath.
//
// The input channel takes one received serial byte per item (rx_byte) under
// in_valid / in_stall. The block searches for SYNC_BYTES sync bytes, checks
// the three header bytes (length, device id, message id), stores the payload
// and compares the final byte with the 8-bit sum of all earlier bytes.
// While a frame is being collected one byte is taken every cycle in which
// in_valid is high. After a checksum byte that matches, the output channel
// (out_valid / out_stall) delivers the PACKET_BYTES bytes of the packet in
// order, starting the next cycle, one byte per cycle while out_stall is low,
// with byte_position counting from zero and last_byte set on the checksum
// byte. A failed packet gives no output. During that run in_stall is high and
// no input byte is taken; the run is paced by the single read port of the
// packet memory, which is read one position ahead. A receiver stall holds the
// current output byte and its position unchanged. Reset (arst_n low) restarts
// the sync search, clears the count and sum and loads sync value 0xFF, device
// id 0xFF and message id 0x14. Configuration (cfg_we, cfg_index, cfg_data) is
// to be written only while the block is idle; the block does not enforce this.
`default_nettype none

`include "sensor_packet_framer_assert.svh"

module sensor_packet_framer
	import spf_pkg::*;
#(
	parameter int PACKET_BYTES = PACKET_BYTES_DEF,
	parameter int SYNC_BYTES = SYNC_BYTES_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [BYTE_W-1:0]    cfg_data,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic [BYTE_W-1:0]    rx_byte,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic      [BYTE_W-1:0]    packet_byte,
	output logic      [POS_W-1:0]     byte_position,
	output logic                      last_byte
);

	spf_cmd_t    cmd;
	spf_status_t status;

	spf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.out_stall(out_stall),
		.status   (status),
		.in_stall (in_stall),
		.out_valid(out_valid),
		.cmd      (cmd)
	);

	spf_dp #(
		.PACKET_BYTES(PACKET_BYTES),
		.SYNC_BYTES  (SYNC_BYTES)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.rx_byte      (rx_byte),
		.cmd          (cmd),
		.status       (status),
		.packet_byte  (packet_byte),
		.byte_position(byte_position),
		.last_byte    (last_byte)
	);

	`SPF_ASSERT_NEXT(a_good_check_starts_run, clk, arst_n,
		cmd.load_last, out_valid && (byte_position == '0), "verified packet did not start at zero")
	`SPF_ASSERT_NEXT(a_run_ends_after_last, clk, arst_n,
		out_valid && !out_stall && last_byte, !out_valid, "output run continued past last byte")
	`SPF_ASSERT_NEXT(a_run_counts_up, clk, arst_n,
		out_valid && !out_stall && !last_byte,
		out_valid && (byte_position == $past(byte_position) + POS_W'(1)),
		"output run skipped or repeated a position")
	`SPF_ASSERT_NOW(a_last_at_end, clk, arst_n,
		out_valid && last_byte, byte_position == POS_W'(PACKET_BYTES - 1),
		"last byte marked away from the final position")

endmodule

`default_nettype wire
